// File: src/kar_pkg.sv
`timescale 1ns / 1ps

package kar_pkg;

    // Action lanes and matrix geometry
    localparam int ACTIONS      = 12;
    localparam int KEY_COLS     = 14;
    localparam int KEY_BITS     = 56;
    localparam int CHAR_W       = 8;
    localparam int FIRST_W      = 4;

    // Time and configuration
    localparam int TIME_BITS_DEFAULT = 32;
    localparam int NOW_W             = 32;
    localparam int CFG_W             = 16;
    localparam int CFG_ADDR_W        = 1;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd450;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd120;

    localparam logic [CFG_ADDR_W-1:0] REG_DELAY    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL = 1'd1;

    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;

    // Stream widths
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 64;

    // Action bit positions
    localparam int ACT_UP     = 0;
    localparam int ACT_DOWN   = 1;
    localparam int ACT_LEFT   = 2;
    localparam int ACT_RIGHT  = 3;
    localparam int ACT_SELECT = 4;
    localparam int ACT_SPACE  = 5;
    localparam int ACT_BACK   = 6;
    localparam int ACT_DELETE = 7;
    localparam int ACT_NUM1   = 8;

    typedef struct packed {
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] interval;
    } kar_cfg_t;

    typedef struct packed {
        logic [ACTIONS-1:0] held;
        logic [CHAR_W-1:0]  cur_char;
    } kar_dec_t;

    typedef struct packed {
        logic [ACTIONS-1:0] just;
        logic [ACTIONS-1:0] rep;
        logic [ACTIONS-1:0] held;
        logic [ACTIONS-1:0] released;
        logic [FIRST_W-1:0] first;
        logic [CHAR_W-1:0]  typed;
    } kar_result_t;

endpackage

// File: src/kar_decode.sv
`timescale 1ns / 1ps

module kar_decode (
    input  logic [kar_pkg::KEY_BITS-1:0] key_matrix,
    input  logic                         button_front,
    input  logic                         flag_enter,
    input  logic                         flag_space,
    input  logic                         flag_delete,
    input  logic                         flag_tab,
    input  logic [kar_pkg::CHAR_W-1:0]   word_char,
    output kar_pkg::kar_dec_t            dec
);

    function automatic int kidx(input int col, input int row);
        return row * kar_pkg::KEY_COLS + col;
    endfunction

    // Map keys and flags onto actions
    always_comb begin
        dec.held = '0;
        dec.held[kar_pkg::ACT_UP]     = key_matrix[kidx(11, 2)] | key_matrix[kidx(2, 1)];
        dec.held[kar_pkg::ACT_DOWN]   = key_matrix[kidx(11, 3)] | key_matrix[kidx(3, 2)];
        dec.held[kar_pkg::ACT_LEFT]   = key_matrix[kidx(10, 3)] | key_matrix[kidx(2, 2)];
        dec.held[kar_pkg::ACT_RIGHT]  = key_matrix[kidx(12, 3)] | key_matrix[kidx(4, 2)];
        dec.held[kar_pkg::ACT_SELECT] = key_matrix[kidx(13, 2)] | button_front | flag_enter;
        dec.held[kar_pkg::ACT_SPACE]  = key_matrix[kidx(13, 3)] | flag_space;
        dec.held[kar_pkg::ACT_BACK]   = key_matrix[kidx(0, 1)] | key_matrix[kidx(1, 1)]
                                      | flag_tab;
        dec.held[kar_pkg::ACT_DELETE] = key_matrix[kidx(13, 0)] | flag_delete;
        for (int i = 0; i < 4; i++) begin
            dec.held[kar_pkg::ACT_NUM1 + i] = key_matrix[kidx(i + 1, 0)];
        end

        // Word character wins, then space, then backspace
        if (word_char != kar_pkg::CHAR_NONE) begin
            dec.cur_char = word_char;
        end else if (flag_space) begin
            dec.cur_char = kar_pkg::CHAR_SPACE;
        end else if (flag_delete) begin
            dec.cur_char = kar_pkg::CHAR_BS;
        end else begin
            dec.cur_char = kar_pkg::CHAR_NONE;
        end
    end

endmodule

// File: src/kar_lane.sv
`timescale 1ns / 1ps

module kar_lane #(
    parameter int TIME_BITS = kar_pkg::TIME_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 active,
    input  logic                 restart,
    input  logic [TIME_BITS-1:0] now,
    input  kar_pkg::kar_cfg_t    cfg,
    output logic                 fire
);

    logic [TIME_BITS-1:0] press_stamp_reg, press_stamp_next;
    logic [TIME_BITS-1:0] repeat_stamp_reg, repeat_stamp_next;
    logic [TIME_BITS-1:0] since_press, since_last;
    logic                 due;

    // Wrapping elapsed times against the repeat thresholds
    assign since_press = now - press_stamp_reg;
    assign since_last  = now - repeat_stamp_reg;
    assign due = (since_press >= TIME_BITS'(cfg.delay))
              && (since_last >= TIME_BITS'(cfg.interval));

    // Fire on a fresh press or when the repeat is due
    always_comb begin
        fire              = 1'b0;
        press_stamp_next  = press_stamp_reg;
        repeat_stamp_next = repeat_stamp_reg;
        if (active) begin
            if (restart) begin
                fire              = 1'b1;
                press_stamp_next  = now;
                repeat_stamp_next = now;
            end else if (due) begin
                fire              = 1'b1;
                repeat_stamp_next = now;
            end
        end
    end

    // Update stamps once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_stamp_reg  <= '0;
            repeat_stamp_reg <= '0;
        end else if (advance) begin
            press_stamp_reg  <= press_stamp_next;
            repeat_stamp_reg <= repeat_stamp_next;
        end
    end

endmodule

// File: src/kar_merge.sv
`timescale 1ns / 1ps

module kar_merge (
    input  logic [kar_pkg::ACTIONS-1:0] rep,
    output logic [kar_pkg::FIRST_W-1:0] first
);

    logic [kar_pkg::ACTIONS-1:0] lowest;

    // Isolate the lowest firing lane and encode it plus one
    assign lowest = rep & (~rep + 1'b1);

    always_comb begin
        first = '0;
        for (int i = 0; i < kar_pkg::ACTIONS; i++) begin
            first = first | ({kar_pkg::FIRST_W{lowest[i]}} & kar_pkg::FIRST_W'(i + 1));
        end
    end

endmodule

// File: src/key_action_autorepeat.sv
`timescale 1ns / 1ps

// Keyboard action decoder with typematic repeat. Each input item is one scan
// tick; twelve action lanes and one character lane run side by side, each
// holding its own press and repeat time stamps, and a merge stage picks the
// lowest firing action. One item is accepted per clock while s_tready is high,
// and its result is registered into the output register, or into the skid entry
// while an earlier result waits there. A two-entry output buffer keeps the input
// side open while one result waits to be taken.
// Configure repeat delay and interval only while no item is in flight.
module key_action_autorepeat #(
    parameter int TIME_BITS = kar_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_we,
    input  logic [kar_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [kar_pkg::CFG_W-1:0]        cfg_wdata,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_matrix[55:0], button_front[56], flag_enter[57], flag_space[58],
    // flag_delete[59], flag_tab[60], word_char[68:61], now_ms[100:69], zero pad
    input  logic [kar_pkg::S_DATA_W-1:0]     s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // just_pressed_mask[11:0], repeat_mask[23:12], held_mask[35:24],
    // released_mask[47:36], first_action[51:48], typed_char[59:52], zero pad
    output logic [kar_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam int A = kar_pkg::ACTIONS;

    kar_pkg::kar_cfg_t           cfg_reg;
    kar_pkg::kar_dec_t           dec;
    kar_pkg::kar_result_t        res;
    logic [A-1:0]                prev_held_reg;
    logic [kar_pkg::CHAR_W-1:0]  prev_char_reg;
    logic [A-1:0]                rep;
    logic                        char_fire;
    logic [63:0]                 now_wide;
    logic [TIME_BITS-1:0]        now;
    logic                        in_fire;
    logic                        out_take;
    logic [kar_pkg::M_DATA_W-1:0] res_word;

    logic                        m_valid_reg, skid_valid_reg;
    logic [kar_pkg::M_DATA_W-1:0] m_data_reg, skid_data_reg;

    assign in_fire  = s_tvalid && s_tready;
    assign out_take = m_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;

    // Take time modulo the stamp width
    assign now_wide = {32'd0, s_tdata[100:69]};
    assign now      = now_wide[TIME_BITS-1:0];

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay    <= kar_pkg::DELAY_RESET;
            cfg_reg.interval <= kar_pkg::INTERVAL_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                kar_pkg::REG_DELAY:    cfg_reg.delay    <= cfg_wdata;
                kar_pkg::REG_INTERVAL: cfg_reg.interval <= cfg_wdata;
                default: ;
            endcase
        end
    end

    kar_decode u_decode (
        .key_matrix   (s_tdata[55:0]),
        .button_front (s_tdata[56]),
        .flag_enter   (s_tdata[57]),
        .flag_space   (s_tdata[58]),
        .flag_delete  (s_tdata[59]),
        .flag_tab     (s_tdata[60]),
        .word_char    (s_tdata[68:61]),
        .dec          (dec)
    );

    // One lane per action
    for (genvar g = 0; g < A; g++) begin : g_lane
        kar_lane #(.TIME_BITS(TIME_BITS)) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (in_fire),
            .active  (dec.held[g]),
            .restart (!prev_held_reg[g]),
            .now     (now),
            .cfg     (cfg_reg),
            .fire    (rep[g])
        );
    end

    // Character lane restarts whenever the character changes
    kar_lane #(.TIME_BITS(TIME_BITS)) u_char_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (in_fire),
        .active  (dec.cur_char != kar_pkg::CHAR_NONE),
        .restart (dec.cur_char != prev_char_reg),
        .now     (now),
        .cfg     (cfg_reg),
        .fire    (char_fire)
    );

    kar_merge u_merge (
        .rep   (rep),
        .first (res.first)
    );

    // Assemble the result item
    assign res.just     = dec.held & ~prev_held_reg;
    assign res.rep      = rep;
    assign res.held     = dec.held;
    assign res.released = prev_held_reg & ~dec.held;
    assign res.typed    = char_fire ? dec.cur_char : kar_pkg::CHAR_NONE;
    assign res_word = {4'd0, res.typed, res.first, res.released, res.held,
                       res.rep, res.just};

    // Hold last-tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_held_reg <= '0;
            prev_char_reg <= kar_pkg::CHAR_NONE;
        end else if (in_fire) begin
            prev_held_reg <= dec.held;
            prev_char_reg <= dec.cur_char;
        end
    end

    // Output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            if (!m_valid_reg || out_take) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (!m_valid_reg || out_take) begin
                m_data_reg <= res_word;
            end else begin
                skid_data_reg <= res_word;
            end
        end else if (out_take && skid_valid_reg) begin
            m_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid without output entry");

    // Every accepted item leaves a result pending
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid)
        else $error("accepted item produced no result");

    // A fresh press always fires its repeat bit
    a_just_in_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[11:0] & ~m_tdata[23:12]) == 12'd0))
        else $error("press edge without repeat pulse");

    // First action tracks the repeat mask
    a_first_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[51:48] == 4'd0) == (m_tdata[23:12] == 12'd0)))
        else $error("first action disagrees with repeat mask");

endmodule
